// ===== rtl/core/tcp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcp_pkg
// shared types and constants of the timeline counter pool
// ----------------------------------------------------------------------------
`default_nettype none

package tcp_pkg;

  localparam int DEPTH     = 256;
  localparam int ID_W      = 8;
  localparam int CNT_W     = 9;
  localparam int VAL_W     = 64;
  localparam int GROW_STEP = 16;

  // operation codes
  localparam logic [3:0] FN_INIT      = 4'd0;
  localparam logic [3:0] FN_ACQUIRE   = 4'd1;
  localparam logic [3:0] FN_RELEASE   = 4'd2;
  localparam logic [3:0] FN_NEXT      = 4'd3;
  localparam logic [3:0] FN_READ      = 4'd4;
  localparam logic [3:0] FN_SIGNAL    = 4'd5;
  localparam logic [3:0] FN_REACHED   = 4'd6;
  localparam logic [3:0] FN_RESET_ALL = 4'd7;
  localparam logic [3:0] FN_STATS     = 4'd8;

  // result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STS_INVALID   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_INITIAL = 2'd0;
  localparam logic [1:0] CFG_MAX     = 2'd1;
  localparam logic [1:0] CFG_GROWTH  = 2'd2;

  typedef struct packed {
    logic [3:0]       func;
    logic [ID_W-1:0]  entry_id;
    logic [VAL_W-1:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  granted_id;
    logic [VAL_W-1:0] result_value;
    logic             reached;
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] busy_count;
    logic [7:0]       growth_count;
    logic [VAL_W-1:0] highest_value;
  } out_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] initial_entries;
    logic [CNT_W-1:0] max_entries;
    logic             growth_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_op;
    logic walk_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcp_ctrl
// sequencer: accept a word, walk entries if needed, hand off the result
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             out_free,
  input  wire tcp_pkg::dp_stat_t stat,
  output tcp_pkg::ctrl_cmd_t    cmd,
  output logic                  in_stall
);
  import tcp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.walk_op ? S_WALK : S_FIN;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.walk_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcp_datapath.sv =====
// ----------------------------------------------------------------------------
// tcp_datapath
// value and free-list memories, busy bits, counters and result forming
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tcp_pkg::cfg_t      cfg,
  input  wire tcp_pkg::in_word_t  in_word,
  input  wire tcp_pkg::ctrl_cmd_t cmd,
  output tcp_pkg::dp_stat_t       stat,
  output tcp_pkg::out_word_t      res
);
  import tcp_pkg::*;

  logic [VAL_W-1:0] val_mem [DEPTH];
  logic [ID_W-1:0]  fifo_mem [DEPTH];

  logic [3:0]       func_r;
  logic [ID_W-1:0]  id_r;
  logic [VAL_W-1:0] opv_r;
  logic [ID_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [7:0]       growth_r, growth_nxt;
  logic [DEPTH-1:0] busy_r, busy_nxt;
  logic [CNT_W-1:0] k_r, len_r, vbase_r;
  logic [ID_W-1:0]  fbase_r;
  logic             grow_r, scan_pend_r;
  logic [VAL_W-1:0] max_r, val_rd_r;
  logic [ID_W-1:0]  fifo_rd_r;

  logic [CNT_W-1:0] bound, room, grow_len, init_len, len_sel;
  logic             can_grow, need_grow, walk_need;
  logic             walking, stats_op, id_ok, busy_hit;
  logic             val_we, val_re, fifo_we;
  logic [ID_W-1:0]  val_wa, val_ra, fifo_wa, fifo_wd;
  logic [VAL_W-1:0] val_wd;
  logic [CNT_W-1:0] walk_idx;

  // growth limits
  assign bound    = (cfg.max_entries > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg.max_entries;
  assign room     = bound - total_r;
  assign grow_len = (room > CNT_W'(GROW_STEP)) ? CNT_W'(GROW_STEP) : room;
  assign init_len = (cfg.initial_entries > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                         : cfg.initial_entries;
  assign can_grow  = cfg.growth_enable && (total_r < bound);
  assign need_grow = (in_word.func == FN_ACQUIRE) && (fill_r == '0) && can_grow;

  always_comb begin
    walk_need = 1'b0;
    len_sel   = '0;
    case (in_word.func)
      FN_INIT:      begin walk_need = 1'b1; len_sel = init_len; end
      FN_RESET_ALL: begin walk_need = 1'b1; len_sel = total_r;  end
      FN_STATS:     begin walk_need = 1'b1; len_sel = total_r;  end
      FN_ACQUIRE:   begin walk_need = need_grow; len_sel = grow_len; end
      default:      begin walk_need = 1'b0; len_sel = '0; end
    endcase
  end

  assign stat.walk_op   = walk_need;
  assign stat.walk_done = (k_r == len_r) && !scan_pend_r;

  assign stats_op = (func_r == FN_STATS);
  assign walking  = cmd.step && (k_r < len_r);
  assign walk_idx = vbase_r + k_r;

  // item capture and walk control
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_word.func;
      id_r    <= in_word.entry_id;
      opv_r   <= in_word.operand_value;
      len_r   <= len_sel;
      grow_r  <= need_grow;
      vbase_r <= need_grow ? total_r : '0;
      fbase_r <= need_grow ? head_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      scan_pend_r <= 1'b0;
    end else begin
      if (cmd.load) k_r <= '0;
      else if (walking) k_r <= k_r + 1'b1;
      scan_pend_r <= walking && stats_op;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) max_r <= '0;
    else if (scan_pend_r && (val_rd_r > max_r)) max_r <= val_rd_r;
  end

  assign id_ok    = {1'b0, id_r} < total_r;
  assign busy_hit = busy_r[id_r];

  // result and state update at finish, plus busy clear at load and walk writes
  always_comb begin
    res          = '0;
    total_nxt    = total_r;
    fill_nxt     = fill_r;
    head_nxt     = head_r;
    growth_nxt   = growth_r;
    busy_nxt     = busy_r;
    val_we       = 1'b0;
    val_wa       = id_r;
    val_wd       = '0;
    fifo_we      = 1'b0;
    fifo_wa      = head_r + fill_r[ID_W-1:0];
    fifo_wd      = id_r;
    res.status   = STS_OK;

    if (cmd.load && ((in_word.func == FN_INIT) || (in_word.func == FN_RESET_ALL))) begin
      busy_nxt = '0;
    end

    if (walking && !stats_op) begin
      val_we  = 1'b1;
      val_wa  = walk_idx[ID_W-1:0];
      fifo_we = 1'b1;
      fifo_wa = fbase_r + k_r[ID_W-1:0];
      fifo_wd = walk_idx[ID_W-1:0];
    end

    if (cmd.finish) begin
      case (func_r)
        FN_INIT: begin
          total_nxt  = len_r;
          fill_nxt   = len_r;
          head_nxt   = '0;
          growth_nxt = '0;
        end
        FN_ACQUIRE: begin
          if (grow_r) begin
            total_nxt      = total_r + len_r;
            fill_nxt       = len_r - 1'b1;
            head_nxt       = head_r + 1'b1;
            growth_nxt     = (growth_r == 8'hFF) ? growth_r : growth_r + 1'b1;
            res.granted_id = vbase_r[ID_W-1:0];
            busy_nxt[vbase_r[ID_W-1:0]] = 1'b1;
          end else if (fill_r == '0) begin
            res.status = STS_EXHAUSTED;
          end else begin
            res.granted_id = fifo_rd_r;
            head_nxt       = head_r + 1'b1;
            fill_nxt       = fill_r - 1'b1;
            busy_nxt[fifo_rd_r] = 1'b1;
            val_we         = 1'b1;
            val_wa         = fifo_rd_r;
          end
        end
        FN_RELEASE: begin
          if (id_ok && busy_hit) begin
            busy_nxt[id_r] = 1'b0;
            val_we         = 1'b1;
            fifo_we        = 1'b1;
            fill_nxt       = fill_r + 1'b1;
          end else begin
            res.status = STS_INVALID;
          end
        end
        FN_NEXT: begin
          if (id_ok) begin
            val_we           = 1'b1;
            val_wd           = val_rd_r + 1'b1;
            res.result_value = val_wd;
          end else res.status = STS_INVALID;
        end
        FN_READ: begin
          if (id_ok) res.result_value = val_rd_r;
          else res.status = STS_INVALID;
        end
        FN_SIGNAL: begin
          if (id_ok) begin
            val_we = 1'b1;
            val_wd = opv_r;
          end else res.status = STS_INVALID;
        end
        FN_REACHED: begin
          if (id_ok) res.reached = (val_rd_r >= opv_r);
          else res.status = STS_INVALID;
        end
        FN_RESET_ALL: begin
          fill_nxt = total_r;
          head_nxt = '0;
        end
        FN_STATS: res.highest_value = max_r;
        default: res.status = STS_INVALID;
      endcase
    end

    res.total_count  = total_nxt;
    res.free_count   = fill_nxt;
    res.busy_count   = total_nxt - fill_nxt;
    res.growth_count = growth_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      fill_r   <= '0;
      total_r  <= '0;
      growth_r <= '0;
      busy_r   <= '0;
    end else begin
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      total_r  <= total_nxt;
      growth_r <= growth_nxt;
      busy_r   <= busy_nxt;
    end
  end

  // memories, registered read
  assign val_re = cmd.load || (walking && stats_op);
  assign val_ra = cmd.load ? in_word.entry_id : k_r[ID_W-1:0];

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (val_re) val_rd_r <= val_mem[val_ra];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
    if (cmd.load) fifo_rd_r <= fifo_mem[head_r];
  end

endmodule

`default_nettype wire

// ===== rtl/core/timeline_counter_pool.sv =====
// ----------------------------------------------------------------------------
// timeline_counter_pool
// pool of 256 timeline counters with a first-in first-out free list
// ----------------------------------------------------------------------------
// usage:
//   in_word carries one operation (func, entry_id, operand_value); it is
//   taken when in_valid is high and in_stall low. one result word per
//   operation appears on out_word under out_valid and is held while
//   out_stall is high.
//   cfg_* writes initial_entries, max_entries and growth_enable; cfg_ready
//   is always high, writes are expected only while the pool is idle.
// sequence:
//   single-entry operations are accepted, then finished from the
//   registered memory read. init and reset-all walk the n entries
//   written, stats walks all entries of the pool and a growing acquire
//   walks the new entries, one entry per cycle through the value and
//   free-list memory write ports (stats reads the value memory instead).
//   one operation is in flight at a time; the next is accepted while the
//   previous result still waits in the output register.
// reset:
//   pool empty, counters zero, config at initial_entries 0, max 256,
//   growth on. a stalled receiver holds the finish step until the output
//   register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module timeline_counter_pool (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tcp_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tcp_pkg::out_word_t      out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [8:0]         cfg_data
);
  import tcp_pkg::*;

  cfg_t      cfg_r;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  out_word_t res;
  out_word_t out_word_r;
  logic      out_valid_r;
  logic      out_free;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_entries <= '0;
      cfg_r.max_entries     <= CNT_W'(DEPTH);
      cfg_r.growth_enable   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INITIAL: cfg_r.initial_entries <= cfg_data;
        CFG_MAX:     cfg_r.max_entries     <= cfg_data;
        CFG_GROWTH:  cfg_r.growth_enable   <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // output register frees when empty or taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  tcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  tcp_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_word (in_word),
    .cmd     (cmd),
    .stat    (stat),
    .res     (res)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_word_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ===== rtl/core/tcp_checker.sv =====
// ----------------------------------------------------------------------------
// tcp_checker
// port-level checks of the timeline counter pool, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire tcp_pkg::out_word_t out_word
);
  import tcp_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // one operation in flight: accept closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // counts stay consistent
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.free_count <= out_word.total_count) &&
      (out_word.busy_count == out_word.total_count - out_word.free_count))
    else $error("inconsistent pool counts");

endmodule

bind timeline_counter_pool tcp_checker u_tcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
